FILE: hdl/atsfp_pkg.sv
// shared types, character codes and defaults for the tri-axis sensor frame parser
package atsfp_pkg;

    localparam int MAX_LINE_BYTES_DEF = 20;
    localparam int VALUE_BITS_DEF     = 16;

    localparam int BYTE_W  = 8;
    localparam int KIND_W  = 2;
    localparam int AXIS_W  = 2;
    localparam int VALUE_W = 16;

    localparam logic [BYTE_W-1:0] CH_GYRO    = 8'h47; // 'G'
    localparam logic [BYTE_W-1:0] CH_ACCEL   = 8'h41; // 'A'
    localparam logic [BYTE_W-1:0] CH_COMPASS = 8'h43; // 'C'
    localparam logic [BYTE_W-1:0] CH_NL      = 8'h0A;
    localparam logic [BYTE_W-1:0] CH_TAB     = 8'h09;
    localparam logic [BYTE_W-1:0] CH_CR      = 8'h0D;
    localparam logic [BYTE_W-1:0] CH_SPACE   = 8'h20;
    localparam logic [BYTE_W-1:0] CH_PLUS    = 8'h2B;
    localparam logic [BYTE_W-1:0] CH_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CH_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CH_NINE    = 8'h39;

    localparam logic [KIND_W-1:0] KIND_GYRO    = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ACCEL   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_COMPASS = 2'd2;

    localparam logic [AXIS_W-1:0] AXIS_X = 2'd0;
    localparam logic [AXIS_W-1:0] AXIS_Z = 2'd2;

    typedef enum logic [1:0] {
        NP_SKIP,
        NP_SIGN,
        NP_DIGITS,
        NP_DONE
    } num_phase_t;

    typedef struct packed {
        logic [KIND_W-1:0]  sensor_kind;
        logic [AXIS_W-1:0]  axis_index;
        logic [VALUE_W-1:0] axis_value;
        logic               value_updated;
        logic               frame_last;
    } result_t;

endpackage

FILE: hdl/atsfp_num_step.sv
// one byte of the per-line integer reader, plus the saturated line value
module atsfp_num_step
    import atsfp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
    input  logic [BYTE_W-1:0]     rx_byte,
    input  num_phase_t            phase,
    input  logic                  neg,
    input  logic [VALUE_BITS:0]   mag,
    output num_phase_t            phase_next,
    output logic                  neg_next,
    output logic [VALUE_BITS:0]   mag_next,
    output logic [VALUE_W-1:0]    line_value
);

    localparam int ACC_W  = VALUE_BITS + 1;
    localparam int PROD_W = ACC_W + 4;
    localparam int EXT_W  = ACC_W + VALUE_W;

    localparam logic [PROD_W-1:0] LIM_P = PROD_W'(1) << (VALUE_BITS - 1);
    localparam logic [ACC_W-1:0]  LIM_A = ACC_W'(1) << (VALUE_BITS - 1);

    logic              is_digit;
    logic              is_ws;
    logic [PROD_W-1:0] prod;
    logic [ACC_W-1:0]  mag_digit;
    logic [EXT_W-1:0]  neg_ext;
    logic [ACC_W-1:0]  pos_clamp;

    assign is_digit = (rx_byte >= CH_ZERO) && (rx_byte <= CH_NINE);
    assign is_ws    = (rx_byte == CH_SPACE) || ((rx_byte >= CH_TAB) && (rx_byte <= CH_CR));

    // times ten by shift and add, then saturate to the magnitude limit
    assign prod = (PROD_W'(mag) << 3) + (PROD_W'(mag) << 1) + PROD_W'(rx_byte[3:0]);
    assign mag_digit = (prod > LIM_P) ? LIM_A : prod[ACC_W-1:0];

    always_comb
    begin
        phase_next = phase;
        neg_next   = neg;
        mag_next   = mag;
        case (phase)
            NP_SKIP:
            begin
                if (is_ws)
                begin
                    phase_next = NP_SKIP;
                end
                else if ((rx_byte == CH_PLUS) || (rx_byte == CH_MINUS))
                begin
                    neg_next   = (rx_byte == CH_MINUS);
                    phase_next = NP_SIGN;
                end
                else if (is_digit)
                begin
                    mag_next   = mag_digit;
                    phase_next = NP_DIGITS;
                end
                else
                begin
                    phase_next = NP_DONE;
                end
            end
            NP_SIGN, NP_DIGITS:
            begin
                if (is_digit)
                begin
                    mag_next   = mag_digit;
                    phase_next = NP_DIGITS;
                end
                else
                begin
                    phase_next = NP_DONE;
                end
            end
            default:
            begin
                phase_next = phase;
            end
        endcase
    end

    // negative wraps at full width so narrow value widths still sign-extend
    assign neg_ext   = EXT_W'(0) - EXT_W'(mag);
    assign pos_clamp = (mag >= LIM_A) ? (LIM_A - ACC_W'(1)) : mag;

    always_comb
    begin
        if (neg)
        begin
            line_value = neg_ext[VALUE_W-1:0];
        end
        else
        begin
            line_value = VALUE_W'(pos_clamp);
        end
    end

endmodule

FILE: hdl/atsfp_out_fifo.sv
// two-entry result buffer that decouples the parser from the output stream
module atsfp_out_fifo
    import atsfp_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push,
    input  result_t push_data,
    output logic    full,
    input  logic    pop_ready,
    output logic    pop_valid,
    output result_t pop_data
);

    result_t      entry_reg [2];
    logic         wr_ptr_reg;
    logic         rd_ptr_reg;
    logic [1:0]   count_reg;
    logic         do_push;
    logic         do_pop;

    assign full      = (count_reg == 2'd2);
    assign pop_valid = (count_reg != 2'd0);
    assign pop_data  = entry_reg[rd_ptr_reg];
    assign do_push   = push && !full;
    assign do_pop    = pop_valid && pop_ready;

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            case ({do_push, do_pop})
                2'b10:   count_reg <= count_reg + 2'd1;
                2'b01:   count_reg <= count_reg - 2'd1;
                default: count_reg <= count_reg;
            endcase
        end
    end

endmodule

FILE: hdl/ascii_triaxis_sensor_frame_parser.sv
// top level of the ascii tri-axis sensor frame parser
//
// Parses text frames of the form header byte ('G' gyro, 'A' accelerometer, 'C' compass),
// newline, then one line each for the x, y and z axes. Each line is read as a decimal
// integer (leading whitespace skipped, optional sign, digits, rest of line ignored) and
// saturated to VALUE_BITS signed bits; every newline that closes an axis line gives one
// result beat, and a line of MAX_LINE_BYTES bytes without a newline gives a beat with
// value_updated low and value zero. One byte is taken per clock cycle while the output buffer
// is not full: a byte sits in the input register, then the frame and line state update
// writes the result into a two-entry output buffer, from which it leaves on the output stream.
// The rate is set by the frame and line state update.
module ascii_triaxis_sensor_frame_parser
    import atsfp_pkg::*;
#(
    parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
    parameter int VALUE_BITS     = VALUE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // [15:0] axis_value
    output logic [4:0]  m_axis_tuser,   // [1:0] sensor_kind, [3:2] axis_index, [4] value_updated
    output logic        m_axis_tlast    // frame_last
);

    localparam int ACC_W = VALUE_BITS + 1;
    localparam int CNT_W = $clog2(MAX_LINE_BYTES + 1);

    typedef enum logic [1:0] {
        FP_IDLE,
        FP_HDR_NL,
        FP_LINES
    } frame_phase_t;

    logic [BYTE_W-1:0] byte_reg;
    logic              byte_valid_reg, byte_valid_next;

    frame_phase_t      frame_reg, frame_next;
    logic [KIND_W-1:0] sensor_reg, sensor_next;
    logic [AXIS_W-1:0] axis_reg, axis_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    num_phase_t        np_reg, np_next;
    logic              neg_reg, neg_next;
    logic [ACC_W-1:0]  mag_reg, mag_next;

    num_phase_t        step_phase;
    logic              step_neg;
    logic [ACC_W-1:0]  step_mag;
    logic [VALUE_W-1:0] line_value;
    logic [CNT_W-1:0]  count_inc;

    logic              fifo_full;
    logic              step_en;
    logic              emit;
    result_t           emit_data;
    result_t           out_data;

    assign step_en       = byte_valid_reg && !fifo_full;
    assign s_axis_tready = !byte_valid_reg || !fifo_full;
    assign count_inc     = count_reg + CNT_W'(1);

    atsfp_num_step #(
        .VALUE_BITS (VALUE_BITS)
    ) u_num_step (
        .rx_byte    (byte_reg),
        .phase      (np_reg),
        .neg        (neg_reg),
        .mag        (mag_reg),
        .phase_next (step_phase),
        .neg_next   (step_neg),
        .mag_next   (step_mag),
        .line_value (line_value)
    );

    always_comb
    begin
        byte_valid_next = byte_valid_reg;
        if (s_axis_tvalid && s_axis_tready)
        begin
            byte_valid_next = 1'b1;
        end
        else if (step_en)
        begin
            byte_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        frame_next  = frame_reg;
        sensor_next = sensor_reg;
        axis_next   = axis_reg;
        count_next  = count_reg;
        np_next     = np_reg;
        neg_next    = neg_reg;
        mag_next    = mag_reg;
        emit        = 1'b0;

        emit_data.sensor_kind   = sensor_reg;
        emit_data.axis_index    = axis_reg;
        emit_data.axis_value    = line_value;
        emit_data.value_updated = 1'b1;
        emit_data.frame_last    = (axis_reg >= AXIS_Z);

        if (step_en)
        begin
            unique case (frame_reg)
                FP_IDLE:
                begin
                    if (byte_reg == CH_GYRO)
                    begin
                        sensor_next = KIND_GYRO;
                        frame_next  = FP_HDR_NL;
                    end
                    else if (byte_reg == CH_ACCEL)
                    begin
                        sensor_next = KIND_ACCEL;
                        frame_next  = FP_HDR_NL;
                    end
                    else if (byte_reg == CH_COMPASS)
                    begin
                        sensor_next = KIND_COMPASS;
                        frame_next  = FP_HDR_NL;
                    end
                end
                FP_HDR_NL:
                begin
                    if (byte_reg == CH_NL)
                    begin
                        frame_next = FP_LINES;
                        axis_next  = AXIS_X;
                        count_next = '0;
                        np_next    = NP_SKIP;
                        neg_next   = 1'b0;
                        mag_next   = '0;
                    end
                    else
                    begin
                        frame_next = FP_IDLE;
                    end
                end
                FP_LINES:
                begin
                    if (byte_reg == CH_NL)
                    begin
                        emit = 1'b1;
                    end
                    else
                    begin
                        np_next    = step_phase;
                        neg_next   = step_neg;
                        mag_next   = step_mag;
                        count_next = count_inc;
                        if (count_inc >= CNT_W'(MAX_LINE_BYTES))
                        begin
                            // overlong line closes the axis without a value
                            emit                    = 1'b1;
                            emit_data.axis_value    = '0;
                            emit_data.value_updated = 1'b0;
                        end
                    end
                    if (emit)
                    begin
                        if (emit_data.frame_last)
                        begin
                            frame_next = FP_IDLE;
                            axis_next  = AXIS_X;
                        end
                        else
                        begin
                            axis_next = axis_reg + AXIS_W'(1);
                        end
                        count_next = '0;
                        np_next    = NP_SKIP;
                        neg_next   = 1'b0;
                        mag_next   = '0;
                    end
                end
                default:
                begin
                    frame_next = FP_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_axis_tvalid && s_axis_tready)
        begin
            byte_reg <= s_axis_tdata;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid_reg <= 1'b0;
            frame_reg      <= FP_IDLE;
            sensor_reg     <= KIND_GYRO;
            axis_reg       <= AXIS_X;
            count_reg      <= '0;
            np_reg         <= NP_SKIP;
            neg_reg        <= 1'b0;
            mag_reg        <= '0;
        end
        else
        begin
            byte_valid_reg <= byte_valid_next;
            frame_reg      <= frame_next;
            sensor_reg     <= sensor_next;
            axis_reg       <= axis_next;
            count_reg      <= count_next;
            np_reg         <= np_next;
            neg_reg        <= neg_next;
            mag_reg        <= mag_next;
        end
    end

    atsfp_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (emit),
        .push_data (emit_data),
        .full      (fifo_full),
        .pop_ready (m_axis_tready),
        .pop_valid (m_axis_tvalid),
        .pop_data  (out_data)
    );

    assign m_axis_tdata = out_data.axis_value;
    assign m_axis_tuser = {out_data.value_updated, out_data.axis_index, out_data.sensor_kind};
    assign m_axis_tlast = out_data.frame_last;

endmodule
